@@ sv/fault_retry_lockout_controller_unit_macros.svh @@
// Assertion macros shared by the checker of the fault retry lockout controller.
// Both sample on the rising edge of aclk.
`ifndef FAULT_RETRY_LOCKOUT_CONTROLLER_UNIT_MACROS_SVH
`define FAULT_RETRY_LOCKOUT_CONTROLLER_UNIT_MACROS_SVH

// Property that is checked only while reset is released.
`define FRLC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("frlc assertion failed");

// Property that is also checked while reset is applied.
`define FRLC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("frlc assertion failed during or after reset");

`endif

@@ sv/frlc_pkg.sv @@
// ----------------------------------------------------------------------------
// frlc_pkg
// Types, status codes, register indexes and timing constants of the fault
// retry lockout controller.
// ----------------------------------------------------------------------------
package frlc_pkg;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_WARNING = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    // Register indexes, taken from paddr bit 2.
    localparam logic REG_MAX_ATTEMPTS    = 1'b0;
    localparam logic REG_RECOVERY_WINDOW = 1'b1;

    localparam int unsigned PADDR_W = 3;

    // Timing constants in milliseconds.
    localparam logic [31:0] HOUR_MS        = 32'd3600000;
    localparam logic [31:0] PUBLISH_GAP_MS = 32'd60000;
    localparam int unsigned MS_PER_S       = 1000;

    // The recovery window in ms is at most 65535 * 1000, which fits 26 bits.
    localparam int unsigned WINDOW_MS_W = 26;

    localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd3;
    localparam logic [15:0] WINDOW_S_RST     = 16'd60;
    localparam logic [7:0]  COUNT_MAX        = 8'd255;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        controller_alarm;
        logic        monitor_alarm;
        logic        user_reset_request;
        logic        publish_accepted;
    } frlc_in_t;

    typedef struct packed {
        logic [1:0]  fault_status;
        logic [7:0]  retry_count;
        logic        restart_pending;
        logic        publish_now;
        logic [31:0] first_fault_ms;
        logic [31:0] last_fault_ms;
        logic        persist_now;
    } frlc_out_t;

    // Configuration as seen by the evaluation core.
    typedef struct packed {
        logic [7:0]             max_attempts;
        logic [WINDOW_MS_W-1:0] window_ms;
    } frlc_cfg_t;

endpackage

@@ sv/frlc_regs.sv @@
// ----------------------------------------------------------------------------
// frlc_regs
// APB configuration registers; the recovery window is also kept in ms.
// ----------------------------------------------------------------------------
module frlc_regs
    import frlc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output frlc_cfg_t          cfg
);

    logic [7:0]             max_attempts_reg, max_attempts_next;
    logic [15:0]            window_s_reg, window_s_next;
    logic [WINDOW_MS_W-1:0] window_ms_reg, window_ms_next;
    logic                   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        max_attempts_next = max_attempts_reg;
        window_s_next     = window_s_reg;
        window_ms_next    = window_ms_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_MAX_ATTEMPTS: begin
                    max_attempts_next = pwdata[7:0];
                end
                REG_RECOVERY_WINDOW: begin
                    window_s_next  = pwdata[15:0];
                    window_ms_next = WINDOW_MS_W'(pwdata[15:0])
                                     * WINDOW_MS_W'(MS_PER_S);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_attempts_reg <= MAX_ATTEMPTS_RST;
            window_s_reg     <= WINDOW_S_RST;
            window_ms_reg    <= WINDOW_MS_W'(WINDOW_S_RST) * WINDOW_MS_W'(MS_PER_S);
        end else begin
            max_attempts_reg <= max_attempts_next;
            window_s_reg     <= window_s_next;
            window_ms_reg    <= window_ms_next;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MAX_ATTEMPTS:    prdata = {24'd0, max_attempts_reg};
            REG_RECOVERY_WINDOW: prdata = {16'd0, window_s_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.max_attempts = max_attempts_reg;
    assign cfg.window_ms    = window_ms_reg;

endmodule

@@ sv/frlc_core.sv @@
// ----------------------------------------------------------------------------
// frlc_core
// Controller state and the combinational evaluation of one tick.
// ----------------------------------------------------------------------------
module frlc_core
    import frlc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      commit,
    input  frlc_in_t  tick,
    input  frlc_cfg_t cfg,
    output frlc_out_t result
);

    logic [1:0]  status_reg, status_next;
    logic [7:0]  count_reg, count_next;
    logic [31:0] first_reg, first_next;
    logic [31:0] last_reg, last_next;
    logic [31:0] pub_reg, pub_next;
    logic        restart_reg, restart_next;
    logic        pending_reg, pending_next;

    logic        alarm;
    logic        restart_a;
    logic [7:0]  count_a;
    logic [7:0]  count_b;
    logic [1:0]  status_b;
    logic        publish;
    logic        persist;

    assign alarm = tick.controller_alarm || tick.monitor_alarm;

    always_comb begin
        // User rearm is honored only in error.
        restart_a = restart_reg || (tick.user_reset_request && status_reg == ST_ERROR);

        // One quiet hour outside error clears the retry count.
        count_a = count_reg;
        if (count_reg != 8'd0 && status_reg != ST_ERROR
            && (tick.now_ms - last_reg) >= HOUR_MS) begin
            count_a = 8'd0;
        end

        first_next   = first_reg;
        last_next    = last_reg;
        count_b      = count_a;
        status_b     = status_reg;
        pending_next = pending_reg;
        persist      = 1'b0;
        if (status_reg == ST_OK && alarm) begin
            if (count_a == 8'd0) begin
                first_next = tick.now_ms;
            end
            if (count_a != COUNT_MAX) begin
                count_b = count_a + 8'd1;
            end
            last_next = tick.now_ms;
            if (count_b >= cfg.max_attempts) begin
                status_b = ST_ERROR;
                persist  = 1'b1;
            end else begin
                status_b = ST_WARNING;
            end
            pending_next = 1'b1;
        end

        restart_next = restart_a;
        status_next  = status_b;
        if (restart_a && !alarm) begin
            restart_next = 1'b0;
            status_next  = ST_OK;
            persist      = 1'b1;
        end

        if (status_next == ST_WARNING
            && (tick.now_ms - last_next) >= {{(32-WINDOW_MS_W){1'b0}}, cfg.window_ms}) begin
            restart_next = 1'b1;
        end

        pub_next = pub_reg;
        publish  = 1'b0;
        if (pending_next && (tick.now_ms - pub_reg) >= PUBLISH_GAP_MS) begin
            pub_next = tick.now_ms;
            publish  = 1'b1;
            if (tick.publish_accepted) begin
                pending_next = 1'b0;
            end
        end
        count_next = count_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg  <= ST_OK;
            count_reg   <= 8'd0;
            first_reg   <= 32'd0;
            last_reg    <= 32'd0;
            pub_reg     <= 32'd0;
            restart_reg <= 1'b0;
            pending_reg <= 1'b0;
        end else if (commit) begin
            status_reg  <= status_next;
            count_reg   <= count_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            pub_reg     <= pub_next;
            restart_reg <= restart_next;
            pending_reg <= pending_next;
        end
    end

    assign result.fault_status    = status_next;
    assign result.retry_count     = count_next;
    assign result.restart_pending = restart_next;
    assign result.publish_now     = publish;
    assign result.first_fault_ms  = first_next;
    assign result.last_fault_ms   = last_next;
    assign result.persist_now     = persist;

endmodule

@@ sv/fault_retry_lockout_controller_unit.sv @@
// ----------------------------------------------------------------------------
// fault_retry_lockout_controller_unit
// Flow: a tick word accepted into the input register is evaluated and moves
// into the result register when that one is free; one evaluation stage.
// Throughput: one tick word per cycle unless the result channel stalls.
// Reset: synchronous on aresetn low; status OK, counters and times cleared,
// max_attempts back to 3 and the recovery window back to 60 s.
// ----------------------------------------------------------------------------
module fault_retry_lockout_controller_unit
    import frlc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // Tick input channel.
    input  logic               s_valid,
    output logic               s_ready,
    input  frlc_in_t           s_data,
    // Result channel.
    output logic               m_valid,
    input  logic               m_ready,
    output frlc_out_t          m_data,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // The block is a two-register pipeline. The input register holds one
    // accepted tick word. The evaluation core reads it together with the
    // controller state, and when the word moves on into the result register
    // the state is committed at the same edge. The input register frees up
    // in that very cycle, so a new word is taken even while a finished
    // result still waits at the output.

    frlc_cfg_t cfg;
    frlc_out_t result;

    logic      in_valid_reg, in_valid_next;
    frlc_in_t  in_word_reg;
    logic      out_valid_reg, out_valid_next;
    frlc_out_t out_word_reg;
    logic      advance;

    frlc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The word in the input register advances when the result register is
    // empty or its word is being taken in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    frlc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (advance),
        .tick    (in_word_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_data;
        end
        if (advance) begin
            out_word_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

endmodule

@@ sv/frlc_checker.sv @@
// ----------------------------------------------------------------------------
// frlc_checker
// Port-level checks on the fault retry lockout controller, bound to the top.
// ----------------------------------------------------------------------------
`include "fault_retry_lockout_controller_unit_macros.svh"

module frlc_checker
    import frlc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input frlc_in_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input frlc_out_t m_data
);

    // A stalled result word holds its value.
    `FRLC_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // The unused status code never appears.
    `FRLC_ASSERT(a_no_bad_status, m_valid |-> (m_data.fault_status == ST_OK || m_data.fault_status == ST_WARNING || m_data.fault_status == ST_ERROR))

    // A save request only comes with entering error or returning to OK.
    `FRLC_ASSERT(a_persist_status,
        m_valid && m_data.persist_now |-> m_data.fault_status != ST_WARNING)

    // Lockout is reached only through a counted fault, and the count is
    // never cleared in error.
    `FRLC_ASSERT(a_error_counted,
        m_valid && m_data.fault_status == ST_ERROR |-> m_data.retry_count != 8'd0)

    // Reset empties the result stage.
    `FRLC_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid)

endmodule

bind fault_retry_lockout_controller_unit frlc_checker u_frlc_checker (.*);
